// ----- rtl/core/i2c_mbs_pkg.sv -----
// Package with the shared types and constants of the I2C master bit sequencer.
`default_nettype none
package i2c_mbs_pkg;

  localparam int unsigned PhaseW = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 4;
  localparam int unsigned OpW    = 3;

  localparam logic [PhaseW-1:0] HalfPhaseReset = 10'd2;
  localparam logic [CntW-1:0]   BitsPerByte    = 4'd8;

  typedef enum logic [OpW-1:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    ST_W_BIT  = 5'd0,
    ST_W_RISE = 5'd1,
    ST_W_FALL = 5'd2,
    ST_A_REL  = 5'd3,
    ST_A_HOLD = 5'd4,
    ST_A_CHK  = 5'd5,
    ST_W_END  = 5'd6,
    ST_R_RISE = 5'd12,
    ST_R_FALL = 5'd13,
    ST_R_ACK  = 5'd14,
    ST_R_END  = 5'd15,
    ST_P_LOW  = 5'd20,
    ST_P_RISE = 5'd21,
    ST_P_SDA  = 5'd22,
    ST_P_END  = 5'd23,
    ST_S_RISE = 5'd24,
    ST_S_SDA  = 5'd25,
    ST_S_FALL = 5'd26,
    ST_S_END  = 5'd27,
    ST_IDLE   = 5'd31
  } step_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] data;
    logic             ack;
    logic             sda;
  } tick_t;

endpackage
`default_nettype wire

// ----- rtl/core/i2c_master_bit_sequencer_core.sv -----
// Top level of the I2C master bit sequencer: front end, item queue and back end.
`default_nettype none
// Each input item is one bus tick. It carries the sampled SDA level and an
// optional command (start, stop, write byte, read byte). A command is only
// taken when the sequencer is idle at that tick; otherwise it is dropped.
// Every input item produces exactly one result item with the SCL and SDA
// drive, the busy and done flags, the last read byte and the ack status.
//
// The front end decodes the operation code and pushes the item into a short
// queue; the back end pops one item per cycle, advances the phase sequencer
// and holds the result in its state registers, which serve as the output
// register. Each item is registered in a queue entry, then in the state
// registers; the block sustains one item per cycle, a rate set by the back
// end, which retires one queued item in every cycle its result slot is free.
//
// When the receiver stalls, the result holds and the back end stops; the
// queue soaks up QUEUE_DEPTH more items before in_stall_o rises. Reset clears
// the sequencer to idle with SCL and SDA driven high and the queue empty, and
// loads a phase length of two ticks (zero acts as one). The user must write
// the phase length register via cfg_we_i only while idle; it is not enforced.
module i2c_master_bit_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [i2c_mbs_pkg::PhaseW-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [i2c_mbs_pkg::OpW-1:0]    operation_i,
  input  wire logic [i2c_mbs_pkg::ByteW-1:0]  write_data_i,
  input  wire logic                           send_ack_i,
  input  wire logic                           sda_in_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           scl_level_o,
  output      logic                           sda_output_enable_o,
  output      logic                           sda_level_o,
  output      logic                           busy_res_o,
  output      logic                           done_res_o,
  output      logic [i2c_mbs_pkg::ByteW-1:0]  read_byte_o,
  output      logic                           status_o
);

  i2c_mbs_pkg::tick_t push_tick, pop_tick;
  logic q_full, q_push, q_valid, q_pop;

  i2c_mbs_front u_front (
    .operation_i  (operation_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .in_valid_i   (in_valid_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .q_push_o     (q_push),
    .q_tick_o     (push_tick)
  );

  i2c_mbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_tick_i (push_tick),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_tick_o  (pop_tick)
  );

  i2c_mbs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .q_valid_i           (q_valid),
    .q_tick_i            (pop_tick),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .scl_level_o         (scl_level_o),
    .sda_output_enable_o (sda_output_enable_o),
    .sda_level_o         (sda_level_o),
    .busy_res_o          (busy_res_o),
    .done_res_o          (done_res_o),
    .read_byte_o         (read_byte_o),
    .status_o            (status_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/i2c_mbs_front.sv -----
// Front end: takes input items and decodes the operation code into a command.
`default_nettype none
module i2c_mbs_front (
  input  wire logic [i2c_mbs_pkg::OpW-1:0]   operation_i,
  input  wire logic [i2c_mbs_pkg::ByteW-1:0] write_data_i,
  input  wire logic                          send_ack_i,
  input  wire logic                          sda_in_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          q_full_i,
  output      logic                          in_stall_o,
  output      logic                          q_push_o,
  output      i2c_mbs_pkg::tick_t            q_tick_o
);

  i2c_mbs_pkg::cmd_e cmd;

  // Codes outside the command set become a plain tick.
  always_comb begin
    case (operation_i)
      i2c_mbs_pkg::CMD_START: cmd = i2c_mbs_pkg::CMD_START;
      i2c_mbs_pkg::CMD_STOP:  cmd = i2c_mbs_pkg::CMD_STOP;
      i2c_mbs_pkg::CMD_WRITE: cmd = i2c_mbs_pkg::CMD_WRITE;
      i2c_mbs_pkg::CMD_READ:  cmd = i2c_mbs_pkg::CMD_READ;
      default:                cmd = i2c_mbs_pkg::CMD_NONE;
    endcase
  end

  assign in_stall_o    = q_full_i;
  assign q_push_o      = in_valid_i && !q_full_i;
  assign q_tick_o.cmd  = cmd;
  assign q_tick_o.data = write_data_i;
  assign q_tick_o.ack  = send_ack_i;
  assign q_tick_o.sda  = sda_in_i;

endmodule
`default_nettype wire

// ----- rtl/core/i2c_mbs_queue.sv -----
// Short flip-flop queue of decoded items between the front and back ends.
`default_nettype none
module i2c_mbs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire i2c_mbs_pkg::tick_t push_tick_i,
  input  wire logic               pop_i,
  output      logic               full_o,
  output      logic               valid_o,
  output      i2c_mbs_pkg::tick_t pop_tick_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  i2c_mbs_pkg::tick_t entry_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_tick_i;
    end
  end

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_tick_o = entry_q[rptr_q];

endmodule
`default_nettype wire

// ----- rtl/core/i2c_mbs_back.sv -----
// Back end: the bus phase sequencer, one tick per item, and the result register.
`default_nettype none
module i2c_mbs_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [i2c_mbs_pkg::PhaseW-1:0]   cfg_wdata_i,
  input  wire logic                             q_valid_i,
  input  wire i2c_mbs_pkg::tick_t               q_tick_i,
  output      logic                             q_pop_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic                             scl_level_o,
  output      logic                             sda_output_enable_o,
  output      logic                             sda_level_o,
  output      logic                             busy_res_o,
  output      logic                             done_res_o,
  output      logic [i2c_mbs_pkg::ByteW-1:0]    read_byte_o,
  output      logic                             status_o
);

  i2c_mbs_pkg::step_e step_q, step_d;
  logic [i2c_mbs_pkg::CntW-1:0]   bit_q, bit_d, bit_inc;
  logic [i2c_mbs_pkg::ByteW-1:0]  shreg_q, shreg_d, rdhold_q, rdhold_d;
  logic [i2c_mbs_pkg::PhaseW-1:0] phase_q, phase_d, phase_inc, limit, half_q;
  logic ack_q, ack_d, scl_q, scl_d, sda_q, sda_d, sden_q, sden_d;
  logic status_q, status_d, done_q, done_d, fin;
  logic out_valid_q, advance;

  // The sequencer state only moves when the result slot is free or being taken.
  assign advance = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = advance;

  assign limit     = (half_q == '0) ? 10'd1 : half_q;
  assign phase_inc = phase_q + 1'b1;
  assign bit_inc   = bit_q + 1'b1;

  always_comb begin
    step_d   = step_q;
    bit_d    = bit_q;
    shreg_d  = shreg_q;
    phase_d  = phase_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    sden_d   = sden_q;
    status_d = status_q;
    rdhold_d = rdhold_q;
    fin      = 1'b0;
    if (step_q == i2c_mbs_pkg::ST_IDLE) begin
      if (q_tick_i.cmd != i2c_mbs_pkg::CMD_NONE) begin
        phase_d = '0;
        bit_d   = '0;
      end
      case (q_tick_i.cmd)
        i2c_mbs_pkg::CMD_START: begin
          sden_d = 1'b1;
          sda_d  = 1'b1;
          step_d = i2c_mbs_pkg::ST_S_RISE;
        end
        i2c_mbs_pkg::CMD_STOP: begin
          sden_d = 1'b1;
          scl_d  = 1'b0;
          step_d = i2c_mbs_pkg::ST_P_LOW;
        end
        i2c_mbs_pkg::CMD_WRITE: begin
          sden_d  = 1'b1;
          scl_d   = 1'b0;
          shreg_d = q_tick_i.data;
          step_d  = i2c_mbs_pkg::ST_W_BIT;
        end
        i2c_mbs_pkg::CMD_READ: begin
          sden_d  = 1'b0;
          sda_d   = 1'b1;
          scl_d   = 1'b0;
          shreg_d = '0;
          ack_d   = q_tick_i.ack;
          step_d  = i2c_mbs_pkg::ST_R_RISE;
        end
        default: ;
      endcase
    end else if (phase_inc >= limit) begin
      phase_d = '0;
      case (step_q)
        i2c_mbs_pkg::ST_W_BIT: begin
          sda_d   = shreg_q[i2c_mbs_pkg::ByteW-1];
          shreg_d = {shreg_q[i2c_mbs_pkg::ByteW-2:0], 1'b0};
          step_d  = i2c_mbs_pkg::ST_W_RISE;
        end
        i2c_mbs_pkg::ST_W_RISE: begin
          scl_d  = 1'b1;
          step_d = i2c_mbs_pkg::ST_W_FALL;
        end
        i2c_mbs_pkg::ST_W_FALL: begin
          bit_d = bit_inc;
          scl_d = 1'b0;
          if (bit_inc < i2c_mbs_pkg::BitsPerByte) begin
            step_d = i2c_mbs_pkg::ST_W_BIT;
          end else begin
            sden_d = 1'b0;
            sda_d  = 1'b1;
            step_d = i2c_mbs_pkg::ST_A_REL;
          end
        end
        i2c_mbs_pkg::ST_A_REL: begin
          scl_d  = 1'b1;
          step_d = i2c_mbs_pkg::ST_A_HOLD;
        end
        i2c_mbs_pkg::ST_A_HOLD: step_d = i2c_mbs_pkg::ST_A_CHK;
        i2c_mbs_pkg::ST_A_CHK: begin
          // A high SDA here is a NACK: flag it and fall into a stop.
          scl_d = 1'b0;
          if (q_tick_i.sda) begin
            status_d = 1'b1;
            sden_d   = 1'b1;
            step_d   = i2c_mbs_pkg::ST_P_LOW;
          end else begin
            status_d = 1'b0;
            step_d   = i2c_mbs_pkg::ST_W_END;
          end
        end
        i2c_mbs_pkg::ST_R_RISE: begin
          scl_d   = 1'b1;
          shreg_d = {shreg_q[i2c_mbs_pkg::ByteW-2:0], q_tick_i.sda};
          step_d  = i2c_mbs_pkg::ST_R_FALL;
        end
        i2c_mbs_pkg::ST_R_FALL: begin
          bit_d = bit_inc;
          scl_d = 1'b0;
          if (bit_inc < i2c_mbs_pkg::BitsPerByte) begin
            step_d = i2c_mbs_pkg::ST_R_RISE;
          end else begin
            sden_d = 1'b1;
            sda_d  = !ack_q;
            step_d = i2c_mbs_pkg::ST_R_ACK;
          end
        end
        i2c_mbs_pkg::ST_R_ACK: begin
          scl_d  = 1'b1;
          step_d = i2c_mbs_pkg::ST_R_END;
        end
        i2c_mbs_pkg::ST_R_END: begin
          scl_d    = 1'b0;
          rdhold_d = shreg_q;
          fin      = 1'b1;
        end
        i2c_mbs_pkg::ST_P_LOW: begin
          sda_d  = 1'b0;
          step_d = i2c_mbs_pkg::ST_P_RISE;
        end
        i2c_mbs_pkg::ST_P_RISE: begin
          scl_d  = 1'b1;
          step_d = i2c_mbs_pkg::ST_P_SDA;
        end
        i2c_mbs_pkg::ST_P_SDA: begin
          sda_d  = 1'b1;
          step_d = i2c_mbs_pkg::ST_P_END;
        end
        i2c_mbs_pkg::ST_S_RISE: begin
          scl_d  = 1'b1;
          step_d = i2c_mbs_pkg::ST_S_SDA;
        end
        i2c_mbs_pkg::ST_S_SDA: begin
          sda_d  = 1'b0;
          step_d = i2c_mbs_pkg::ST_S_FALL;
        end
        i2c_mbs_pkg::ST_S_FALL: begin
          scl_d  = 1'b0;
          step_d = i2c_mbs_pkg::ST_S_END;
        end
        default: fin = 1'b1;
      endcase
    end else begin
      phase_d = phase_inc;
    end
    if (fin) begin
      step_d = i2c_mbs_pkg::ST_IDLE;
    end
    done_d = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= i2c_mbs_pkg::ST_IDLE;
      bit_q       <= '0;
      shreg_q     <= '0;
      phase_q     <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      sden_q      <= 1'b1;
      status_q    <= 1'b0;
      rdhold_q    <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      half_q      <= i2c_mbs_pkg::HalfPhaseReset;
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (advance) begin
        step_q   <= step_d;
        bit_q    <= bit_d;
        shreg_q  <= shreg_d;
        phase_q  <= phase_d;
        ack_q    <= ack_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        sden_q   <= sden_d;
        status_q <= status_d;
        rdhold_q <= rdhold_d;
        done_q   <= done_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The sequencer registers double as the result register.
  assign out_valid_o         = out_valid_q;
  assign scl_level_o         = scl_q;
  assign sda_output_enable_o = sden_q;
  assign sda_level_o         = sden_q ? sda_q : 1'b1;
  assign busy_res_o          = (step_q != i2c_mbs_pkg::ST_IDLE);
  assign done_res_o          = done_q;
  assign read_byte_o         = rdhold_q;
  assign status_o            = status_q;

endmodule
`default_nettype wire

// ----- rtl/core/i2c_mbs_checker.sv -----
// Port-level assertions for the I2C master bit sequencer and their bind.
`default_nettype none
module i2c_mbs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic                           scl_level_o,
  input wire logic                           sda_output_enable_o,
  input wire logic                           sda_level_o,
  input wire logic                           busy_res_o,
  input wire logic                           done_res_o,
  input wire logic [i2c_mbs_pkg::ByteW-1:0]  read_byte_o
);

  // A finished command leaves the sequencer idle on that same item.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // A released SDA line always reads high.
  a_released_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_output_enable_o |-> sda_level_o)
    else $error("released SDA not reported high");

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scl_level_o)
      && $stable(done_res_o) && $stable(read_byte_o))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer_core i2c_mbs_checker u_i2c_mbs_checker (.*);
`default_nettype wire

// ----- sim/i2c_master_bit_sequencer_core_tb.sv -----
// Self-checking testbench for the I2C master bit sequencer core.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_tb;

  // Operation codes above CMD_READ are reserved. The sequencer must treat them
  // like CMD_NONE, so they are sent on purpose to toggle the top opcode bit.
  localparam logic [i2c_mbs_pkg::OpW-1:0] OpReservedFirst = 3'd5;

  // A run fails if no item moves on either side for this many cycles. The
  // longest quiet stretch in a correct run is the output hold-off plus a few
  // random stalls, which is far below this.
  localparam int unsigned QuietLimit = 4000;

  // The hold-off forced on the result side to fill the block's item queue.
  localparam int unsigned HoldOffCycles = 80;

  // A phase length well above the short ones used elsewhere.
  localparam logic [i2c_mbs_pkg::PhaseW-1:0] LongPhase = 10'd24;

  // The result of one tick, as seen on the output ports.
  typedef struct packed {
    logic                          scl;
    logic                          sda_oe;
    logic                          sda_lvl;
    logic                          busy;
    logic                          done;
    logic [i2c_mbs_pkg::ByteW-1:0] rd_byte;
    logic                          status;
  } bus_res_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [i2c_mbs_pkg::PhaseW-1:0] cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [i2c_mbs_pkg::OpW-1:0]    operation_i;
  logic [i2c_mbs_pkg::ByteW-1:0]  write_data_i;
  logic                           send_ack_i;
  logic                           sda_in_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic                           scl_level_o;
  logic                           sda_output_enable_o;
  logic                           sda_level_o;
  logic                           busy_res_o;
  logic                           done_res_o;
  logic [i2c_mbs_pkg::ByteW-1:0]  read_byte_o;
  logic                           status_o;

  i2c_master_bit_sequencer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .write_data_i       (write_data_i),
    .send_ack_i         (send_ack_i),
    .sda_in_i           (sda_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .scl_level_o        (scl_level_o),
    .sda_output_enable_o(sda_output_enable_o),
    .sda_level_o        (sda_level_o),
    .busy_res_o         (busy_res_o),
    .done_res_o         (done_res_o),
    .read_byte_o        (read_byte_o),
    .status_o           (status_o)
  );

  // Bus model state. It mirrors the sequencer and is advanced once for every
  // tick that the block accepts, in the order of acceptance.
  logic [i2c_mbs_pkg::PhaseW-1:0] m_half;
  i2c_mbs_pkg::step_e             m_step;
  logic [i2c_mbs_pkg::CntW-1:0]   m_bits;
  logic [i2c_mbs_pkg::ByteW-1:0]  m_shift;
  logic [i2c_mbs_pkg::PhaseW-1:0] m_phase;
  logic                           m_ack_sel;
  logic                           m_scl;
  logic                           m_sda;
  logic                           m_sda_en;
  logic                           m_status;
  logic [i2c_mbs_pkg::ByteW-1:0]  m_last_read;

  // Bus results that are predicted but not yet seen at the output, oldest first.
  bus_res_t expected_bus_q[$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned fail_count;
  int unsigned tick_count;
  int unsigned results_checked;
  int unsigned cmds_taken;
  int unsigned nack_count;
  int unsigned reads_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Bus model
  // ---------------------------------------------------------------------------

  task automatic reset_bus_model();
    m_half      = i2c_mbs_pkg::HalfPhaseReset;
    m_step      = i2c_mbs_pkg::ST_IDLE;
    m_bits      = '0;
    m_shift     = '0;
    m_phase     = '0;
    m_ack_sel   = 1'b0;
    m_scl       = 1'b1;
    m_sda       = 1'b1;
    m_sda_en    = 1'b1;
    m_status    = 1'b0;
    m_last_read = '0;
  endtask

  // Closes the current bus phase and sets up the drive of the next one.
  // Sets cmd_done when the running command has finished.
  task automatic close_bus_phase(input logic sda, output logic cmd_done);
    cmd_done = 1'b0;
    case (m_step)
      i2c_mbs_pkg::ST_W_BIT: begin
        m_sda   = m_shift[i2c_mbs_pkg::ByteW-1];
        m_shift = {m_shift[i2c_mbs_pkg::ByteW-2:0], 1'b0};
        m_step  = i2c_mbs_pkg::ST_W_RISE;
      end
      i2c_mbs_pkg::ST_W_RISE: begin
        m_scl  = 1'b1;
        m_step = i2c_mbs_pkg::ST_W_FALL;
      end
      i2c_mbs_pkg::ST_W_FALL: begin
        m_bits = m_bits + 1'b1;
        m_scl  = 1'b0;
        if (m_bits < i2c_mbs_pkg::BitsPerByte) begin
          m_step = i2c_mbs_pkg::ST_W_BIT;
        end else begin
          // Release SDA so that the slave can drive the acknowledge.
          m_sda_en = 1'b0;
          m_sda    = 1'b1;
          m_step   = i2c_mbs_pkg::ST_A_REL;
        end
      end
      i2c_mbs_pkg::ST_A_REL: begin
        m_scl  = 1'b1;
        m_step = i2c_mbs_pkg::ST_A_HOLD;
      end
      i2c_mbs_pkg::ST_A_HOLD: m_step = i2c_mbs_pkg::ST_A_CHK;
      i2c_mbs_pkg::ST_A_CHK: begin
        m_scl = 1'b0;
        if (sda) begin
          // The slave did not acknowledge: flag it and run a stop.
          m_status = 1'b1;
          m_sda_en = 1'b1;
          m_step   = i2c_mbs_pkg::ST_P_LOW;
          nack_count++;
        end else begin
          m_status = 1'b0;
          m_step   = i2c_mbs_pkg::ST_W_END;
        end
      end
      i2c_mbs_pkg::ST_R_RISE: begin
        m_scl   = 1'b1;
        m_shift = {m_shift[i2c_mbs_pkg::ByteW-2:0], sda};
        m_step  = i2c_mbs_pkg::ST_R_FALL;
      end
      i2c_mbs_pkg::ST_R_FALL: begin
        m_bits = m_bits + 1'b1;
        m_scl  = 1'b0;
        if (m_bits < i2c_mbs_pkg::BitsPerByte) begin
          m_step = i2c_mbs_pkg::ST_R_RISE;
        end else begin
          m_sda_en = 1'b1;
          m_sda    = ~m_ack_sel;
          m_step   = i2c_mbs_pkg::ST_R_ACK;
        end
      end
      i2c_mbs_pkg::ST_R_ACK: begin
        m_scl  = 1'b1;
        m_step = i2c_mbs_pkg::ST_R_END;
      end
      i2c_mbs_pkg::ST_R_END: begin
        m_scl       = 1'b0;
        m_last_read = m_shift;
        cmd_done    = 1'b1;
        reads_done++;
      end
      i2c_mbs_pkg::ST_P_LOW: begin
        m_sda  = 1'b0;
        m_step = i2c_mbs_pkg::ST_P_RISE;
      end
      i2c_mbs_pkg::ST_P_RISE: begin
        m_scl  = 1'b1;
        m_step = i2c_mbs_pkg::ST_P_SDA;
      end
      i2c_mbs_pkg::ST_P_SDA: begin
        m_sda  = 1'b1;
        m_step = i2c_mbs_pkg::ST_P_END;
      end
      i2c_mbs_pkg::ST_S_RISE: begin
        m_scl  = 1'b1;
        m_step = i2c_mbs_pkg::ST_S_SDA;
      end
      i2c_mbs_pkg::ST_S_SDA: begin
        m_sda  = 1'b0;
        m_step = i2c_mbs_pkg::ST_S_FALL;
      end
      i2c_mbs_pkg::ST_S_FALL: begin
        m_scl  = 1'b0;
        m_step = i2c_mbs_pkg::ST_S_END;
      end
      default: cmd_done = 1'b1;
    endcase
  endtask

  // Advances the bus model by one tick and returns the drive it predicts.
  task automatic predict_bus_tick(input logic [i2c_mbs_pkg::OpW-1:0] op,
                                  input logic [i2c_mbs_pkg::ByteW-1:0] data,
                                  input logic ack, input logic sda, output bus_res_t res);
    logic [i2c_mbs_pkg::PhaseW-1:0] limit;
    logic                           cmd_done;
    limit    = (m_half == '0) ? i2c_mbs_pkg::PhaseW'(1) : m_half;
    cmd_done = 1'b0;
    if (m_step == i2c_mbs_pkg::ST_IDLE) begin
      // Commands are only taken on a tick that starts idle.
      if (op >= i2c_mbs_pkg::CMD_START && op <= i2c_mbs_pkg::CMD_READ) begin
        m_phase = '0;
        m_bits  = '0;
        cmds_taken++;
        case (op)
          i2c_mbs_pkg::CMD_START: begin
            m_sda_en = 1'b1;
            m_sda    = 1'b1;
            m_step   = i2c_mbs_pkg::ST_S_RISE;
          end
          i2c_mbs_pkg::CMD_STOP: begin
            m_sda_en = 1'b1;
            m_scl    = 1'b0;
            m_step   = i2c_mbs_pkg::ST_P_LOW;
          end
          i2c_mbs_pkg::CMD_WRITE: begin
            m_sda_en = 1'b1;
            m_scl    = 1'b0;
            m_shift  = data;
            m_step   = i2c_mbs_pkg::ST_W_BIT;
          end
          default: begin
            m_sda_en  = 1'b0;
            m_sda     = 1'b1;
            m_scl     = 1'b0;
            m_shift   = '0;
            m_ack_sel = ack;
            m_step    = i2c_mbs_pkg::ST_R_RISE;
          end
        endcase
      end
    end else begin
      m_phase = m_phase + 1'b1;
      if (m_phase >= limit) begin
        m_phase = '0;
        close_bus_phase(sda, cmd_done);
        if (cmd_done) begin
          m_step = i2c_mbs_pkg::ST_IDLE;
        end
      end
    end
    res.scl     = m_scl;
    res.sda_oe  = m_sda_en;
    res.sda_lvl = m_sda_en ? m_sda : 1'b1;
    res.busy    = (m_step != i2c_mbs_pkg::ST_IDLE);
    res.done    = cmd_done;
    res.rd_byte = m_last_read;
    res.status  = m_status;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one tick, with random idle cycles ahead of it, and waits until the
  // block takes it. Valid stays high after acceptance; the caller that stops
  // sending lowers it.
  task automatic send_tick(input logic [i2c_mbs_pkg::OpW-1:0] op,
                           input logic [i2c_mbs_pkg::ByteW-1:0] data,
                           input logic ack, input logic sda);
    bus_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    write_data_i <= data;
    send_ack_i   <= ack;
    sda_in_i     <= sda;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_bus_tick(op, data, ack, sda, res);
    expected_bus_q.push_back(res);
    tick_count++;
  endtask

  // Sends one tick while a command runs. SDA follows the slave we pretend to
  // be: nack_level during the acknowledge check, the bits of sda_byte while a
  // read samples, and noise elsewhere. Commands sent here must be dropped.
  task automatic send_busy_tick(input logic nack_level,
                                input logic [i2c_mbs_pkg::ByteW-1:0] sda_byte,
                                input int unsigned noise_pct);
    logic [i2c_mbs_pkg::OpW-1:0] op;
    logic                        sda;
    op = i2c_mbs_pkg::CMD_NONE;
    if ($urandom_range(99) < noise_pct) begin
      op = i2c_mbs_pkg::OpW'($urandom_range((1 << i2c_mbs_pkg::OpW) - 1));
    end
    if (m_step == i2c_mbs_pkg::ST_A_CHK) begin
      sda = nack_level;
    end else if (m_step == i2c_mbs_pkg::ST_R_RISE) begin
      sda = sda_byte[3'(i2c_mbs_pkg::BitsPerByte - 1 - m_bits)];
    end else begin
      sda = 1'($urandom);
    end
    send_tick(op, i2c_mbs_pkg::ByteW'($urandom), 1'($urandom), sda);
  endtask

  // Issues one operation and runs the bus until the sequencer is idle again.
  task automatic run_command(input logic [i2c_mbs_pkg::OpW-1:0] op,
                             input logic [i2c_mbs_pkg::ByteW-1:0] data,
                             input logic ack, input logic nack_level,
                             input logic [i2c_mbs_pkg::ByteW-1:0] sda_byte,
                             input int unsigned noise_pct);
    send_tick(op, data, ack, 1'($urandom));
    while (m_step != i2c_mbs_pkg::ST_IDLE) begin
      send_busy_tick(nack_level, sda_byte, noise_pct);
    end
  endtask

  // Stops offering ticks and waits for every predicted result to arrive.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_bus_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes the phase length once the sequencer and the item queue are empty.
  task automatic set_phase_len(input logic [i2c_mbs_pkg::PhaseW-1:0] ticks);
    while (m_step != i2c_mbs_pkg::ST_IDLE) begin
      send_busy_tick(1'($urandom), i2c_mbs_pkg::ByteW'($urandom), 0);
    end
    wait_drain();
    // The back end may still hold the last item in its state registers.
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_half = ticks;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command at the reset phase length: plain and NACKed writes, reads
  // with ACK and NACK, reserved codes while idle, and commands thrown at the
  // sequencer on every busy tick, the completing tick included.
  task automatic test_directed_commands();
    run_command(i2c_mbs_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0, 8'h00, 0);
    run_command(i2c_mbs_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 8'h00, 0);
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0, 8'h00, 0);
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b0, 8'hFF, 0);
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b1, 8'h00, 0);
    run_command(i2c_mbs_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 8'h00, 0);
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'h5A, 1'b1, 1'b1, 8'hFF, 0);
    run_command(i2c_mbs_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 8'hFF, 0);
    run_command(i2c_mbs_pkg::CMD_READ, 8'hFF, 1'b0, 1'b0, 8'h00, 0);
    run_command(i2c_mbs_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 8'hC3, 0);
    for (int c = OpReservedFirst; c < (1 << i2c_mbs_pkg::OpW); c++) begin
      run_command(i2c_mbs_pkg::OpW'(c), 8'hFF, 1'b1, 1'b1, 8'hFF, 0);
    end
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'h3C, 1'b0, 1'b0, 8'h00, 100);
    run_command(i2c_mbs_pkg::CMD_READ, 8'h96, 1'b0, 1'b0, 8'h69, 100);
    run_command(i2c_mbs_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 0);
  endtask

  // Phase lengths of zero, which must act as one, of one, and a long one.
  task automatic test_phase_lengths();
    set_phase_len('0);
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'h81, 1'b0, 1'b0, 8'h00, 10);
    run_command(i2c_mbs_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 8'h7E, 10);
    set_phase_len(i2c_mbs_pkg::PhaseW'(1));
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'h42, 1'b0, 1'b1, 8'h00, 10);
    set_phase_len(LongPhase);
    run_command(i2c_mbs_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 8'h00, 0);
    run_command(i2c_mbs_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 0);
    set_phase_len(i2c_mbs_pkg::HalfPhaseReset);
  endtask

  // The result side holds off for a long stretch while ticks keep coming, so
  // the item queue fills and the block must stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    run_command(i2c_mbs_pkg::CMD_WRITE, 8'hE7, 1'b0, 1'b0, 8'h00, 0);
  endtask

  // One phase of random traffic: mostly well-formed commands with random
  // content, some reserved codes, noise while busy and short idle spells.
  task automatic run_traffic_phase(input int unsigned idle_pct, input int unsigned stall,
                                   input int unsigned n_ticks);
    int unsigned                 first;
    logic [i2c_mbs_pkg::OpW-1:0] op;
    set_phase_len(i2c_mbs_pkg::PhaseW'($urandom_range(4, 1)));
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    first         = tick_count;
    while (tick_count - first < n_ticks) begin
      if ($urandom_range(99) < 85) begin
        op = i2c_mbs_pkg::OpW'($urandom_range(i2c_mbs_pkg::CMD_READ,
                                               i2c_mbs_pkg::CMD_START));
      end else begin
        op = i2c_mbs_pkg::OpW'($urandom_range((1 << i2c_mbs_pkg::OpW) - 1));
      end
      run_command(op, i2c_mbs_pkg::ByteW'($urandom), 1'($urandom),
                  ($urandom_range(99) < 30), i2c_mbs_pkg::ByteW'($urandom), 15);
      repeat ($urandom_range(2)) begin
        send_tick(i2c_mbs_pkg::CMD_NONE, i2c_mbs_pkg::ByteW'($urandom), 1'($urandom),
                  1'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 60);
    run_traffic_phase(55, 0, 60);
    run_traffic_phase(0, 55, 60);
    run_traffic_phase(10, 10, 60);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, the forced hold-off, checking and watchdog
  // ---------------------------------------------------------------------------

  initial begin : result_stall
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    bus_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bus_q.size() == 0) begin
        $error("result arrived with no tick outstanding");
        fail_count++;
      end else begin
        want = expected_bus_q.pop_front();
        results_checked++;
        check_field("scl_level", want.scl, scl_level_o);
        check_field("sda_output_enable", want.sda_oe, sda_output_enable_o);
        check_field("sda_level", want.sda_lvl, sda_level_o);
        check_field("busy_res", want.busy, busy_res_o);
        check_field("done_res", want.done, done_res_o);
        check_field("read_byte", want.rd_byte, read_byte_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  // Ends the run if nothing moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("timeout: no item moved for %0d cycles", QuietLimit);
        $display("i2c_master_bit_sequencer_core test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_req        = 1'b0;
    fail_count      = 0;
    tick_count      = 0;
    results_checked = 0;
    cmds_taken      = 0;
    nack_count      = 0;
    reads_done      = 0;
    reset_bus_model();
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= i2c_mbs_pkg::HalfPhaseReset;
    in_valid_i   <= 1'b0;
    operation_i  <= i2c_mbs_pkg::CMD_NONE;
    write_data_i <= '0;
    send_ack_i   <= 1'b0;
    sda_in_i     <= 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_commands();
    test_phase_lengths();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (expected_bus_q.size() != 0) begin
      $error("%0d predicted results never arrived", expected_bus_q.size());
      fail_count++;
    end
    $display("Ran %0d bus ticks and checked %0d results: %0d commands taken, %0d reads,",
             tick_count, results_checked, cmds_taken, reads_done);
    $display("%0d NACKed writes, short and long phase lengths, idle and stall mixes, hold-off.",
             nack_count);
    if (fail_count == 0) begin
      $display("i2c_master_bit_sequencer_core test passed");
    end else begin
      $display("i2c_master_bit_sequencer_core test failed");
    end
    $finish;
  end

endmodule
